[hdl/brtl_pkg.sv]
// ----------------------------------------------------------------------------
// brtl_pkg
// Shared widths, defaults, request codes, FSM encoding and popcount for the
// two-level rank engine.
// ----------------------------------------------------------------------------
package brtl_pkg;

   localparam int MAX_WORDS_DEF   = 4096;
   localparam int WORDS_PER_BLOCK = 8;
   localparam int WORD_W          = 64;
   localparam int POS_W           = 18;
   localparam int RANK_W          = 18;
   localparam int ONES_W          = 19;
   localparam int REL_W           = 9;
   localparam int REL_ALL_W       = REL_W * (WORDS_PER_BLOCK - 1);
   localparam int BLK_W           = ONES_W + REL_ALL_W;
   localparam int BIT_W           = 6;
   localparam int SLOT_W          = 3;
   localparam int POP_W           = 7;

   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      Q_IDLE = 3'b001,
      Q_LOOK = 3'b010,
      Q_SUM  = 3'b100
   } q_state_type;

   // adder tree, six levels
   function automatic logic [POP_W-1:0] ones64(input logic [WORD_W-1:0] v);
      logic [1:0] s1 [32];
      logic [2:0] s2 [16];
      logic [3:0] s3 [8];
      logic [4:0] s4 [4];
      logic [5:0] s5 [2];
      for (int i = 0; i < 32; i++) begin
         s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      end
      for (int i = 0; i < 16; i++) begin
         s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
      end
      return {1'b0, s5[0]} + {1'b0, s5[1]};
   endfunction

endpackage

[hdl/brtl_if.sv]
// ----------------------------------------------------------------------------
// brtl_req_if / brtl_rsp_if
// Valid/ready channels for requests and results of the rank engine.
// ----------------------------------------------------------------------------
interface brtl_req_if;
   import brtl_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic              first_word;
   logic [WORD_W-1:0] word;
   logic [POS_W-1:0]  position;

   modport source (output valid, action, first_word, word, position, input ready);
   modport sink   (input valid, action, first_word, word, position, output ready);
endinterface

interface brtl_rsp_if;
   import brtl_pkg::*;

   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank_count;
   logic              out_of_range;

   modport source (output valid, rank_count, out_of_range, input ready);
   modport sink   (input valid, rank_count, out_of_range, output ready);
endinterface

[hdl/bitvector_rank_two_level.sv]
// ----------------------------------------------------------------------------
// bitvector_rank_two_level
// Two-level rank engine over a bit vector held in on-chip memory.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (valid/ready). An append request (action 0)
// stores its 64-bit word and updates the block counts; it gives no result.
// first_word restarts the vector. Words past MAX_WORDS are dropped.
// A query request (action 1) returns on rsp_chan the ones count strictly
// before position, or zero with out_of_range when position is not below the
// loaded bit count. A query steps through the word and block memory reads,
// the masked popcount and relative-count select, and the final add into the
// output register, and holds the engine until that add is done. Appends
// sustain one per cycle while no query holds the engine.
// The output register lets the next request be accepted while a result
// waits; a further query holds in its final step until rsp_chan frees.
// Reset clears the word count, running count, state and output valid; the
// memories are not cleared; an out-of-range query may read unwritten entries.
// ----------------------------------------------------------------------------
module bitvector_rank_two_level #(
   parameter int MAX_WORDS = brtl_pkg::MAX_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   brtl_req_if.sink   req_chan,
   brtl_rsp_if.source rsp_chan
);
   import brtl_pkg::*;

   localparam int NUM_BLOCKS = (MAX_WORDS + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK;
   localparam int AW         = $clog2(MAX_WORDS);
   localparam int BW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW         = $clog2(MAX_WORDS + 1);

   logic              accept;
   logic              append;
   logic              start;
   logic              idle;
   logic              word_wr_en;
   logic [AW-1:0]     word_wr_addr;
   logic              blk_wr_en;
   logic [BW-1:0]     blk_wr_addr;
   logic [BLK_W-1:0]  blk_wr_data;
   logic [CW-1:0]     words_loaded;
   logic              rd_en;
   logic [AW-1:0]     word_rd_addr;
   logic [BW-1:0]     blk_rd_addr;
   logic [WORD_W-1:0] word_rd_data;
   logic [BLK_W-1:0]  blk_rd_data;

   assign req_chan.ready = idle;
   assign accept         = req_chan.valid && idle;
   assign append         = accept && (req_chan.action == ACT_APPEND);
   assign start          = accept && (req_chan.action == ACT_QUERY);

   brtl_load #(
      .MAX_WORDS (MAX_WORDS),
      .AW        (AW),
      .BW        (BW),
      .CW        (CW)
   ) u_load (
      .clock        (clock),
      .reset        (reset),
      .append       (append),
      .first_word   (req_chan.first_word),
      .word         (req_chan.word),
      .word_wr_en   (word_wr_en),
      .word_wr_addr (word_wr_addr),
      .blk_wr_en    (blk_wr_en),
      .blk_wr_addr  (blk_wr_addr),
      .blk_wr_data  (blk_wr_data),
      .words_loaded (words_loaded)
   );

   brtl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WORDS),
      .AW    (AW)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (word_wr_en),
      .wr_addr (word_wr_addr),
      .wr_data (req_chan.word),
      .rd_en   (rd_en),
      .rd_addr (word_rd_addr),
      .rd_data (word_rd_data)
   );

   brtl_ram #(
      .WIDTH (BLK_W),
      .DEPTH (NUM_BLOCKS),
      .AW    (BW)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_data (blk_wr_data),
      .rd_en   (rd_en),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   brtl_query #(
      .MAX_WORDS (MAX_WORDS),
      .AW        (AW),
      .BW        (BW),
      .CW        (CW)
   ) u_query (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .position     (req_chan.position),
      .words_loaded (words_loaded),
      .idle         (idle),
      .rd_en        (rd_en),
      .word_rd_addr (word_rd_addr),
      .blk_rd_addr  (blk_rd_addr),
      .word_rd_data (word_rd_data),
      .blk_rd_data  (blk_rd_data),
      .rsp_chan     (rsp_chan)
   );

endmodule

[hdl/brtl_ram.sv]
// ----------------------------------------------------------------------------
// brtl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brtl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/brtl_load.sv]
// ----------------------------------------------------------------------------
// brtl_load
// Append path: word count, running ones count and per-block counts, written
// to the word and block memories one word per cycle.
// ----------------------------------------------------------------------------
module brtl_load #(
   parameter int MAX_WORDS = brtl_pkg::MAX_WORDS_DEF,
   parameter int AW        = $clog2(MAX_WORDS),
   parameter int BW        = (((MAX_WORDS + 7) / 8) > 1) ? $clog2((MAX_WORDS + 7) / 8) : 1,
   parameter int CW        = $clog2(MAX_WORDS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         append,
   input  logic                         first_word,
   input  logic [brtl_pkg::WORD_W-1:0]  word,
   output logic                         word_wr_en,
   output logic [AW-1:0]                word_wr_addr,
   output logic                         blk_wr_en,
   output logic [BW-1:0]                blk_wr_addr,
   output logic [brtl_pkg::BLK_W-1:0]   blk_wr_data,
   output logic [CW-1:0]                words_loaded
);
   import brtl_pkg::*;

   logic [CW-1:0]        words_ff, words_in;
   logic [ONES_W-1:0]    ones_ff, ones_in;
   logic [ONES_W-1:0]    base_ff, base_in;
   logic [REL_ALL_W-1:0] rel_ff, rel_in;
   logic [CW-1:0]        idx;
   logic [ONES_W-1:0]    ones_now;
   logic [ONES_W-1:0]    diff;
   logic [SLOT_W-1:0]    slot;
   logic                 full;
   logic                 store;

   always_comb begin
      idx      = first_word ? '0 : words_ff;
      ones_now = first_word ? '0 : ones_ff;
      full     = (idx == CW'(MAX_WORDS));
      store    = append && !full;
      slot     = idx[SLOT_W-1:0];
      diff     = ones_now - base_ff;

      words_in = words_ff;
      ones_in  = ones_ff;
      base_in  = base_ff;
      rel_in   = rel_ff;
      if (store) begin
         words_in = idx + CW'(1);
         ones_in  = ones_now + ONES_W'(ones64(word));
         if (slot == '0) begin
            base_in = ones_now;
            rel_in  = '0;
         end else begin
            for (int f = 1; f < WORDS_PER_BLOCK; f++) begin
               if (slot == SLOT_W'(f)) begin
                  rel_in[REL_W*(WORDS_PER_BLOCK-1-f) +: REL_W] = diff[REL_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
         ones_ff  <= '0;
      end else begin
         words_ff <= words_in;
         ones_ff  <= ones_in;
      end
      base_ff <= base_in;
      rel_ff  <= rel_in;
   end

   assign word_wr_en   = store;
   assign word_wr_addr = idx[AW-1:0];
   assign blk_wr_en    = store;
   assign blk_wr_addr  = idx[BW+SLOT_W-1:SLOT_W];
   assign blk_wr_data  = {base_in, rel_in};
   assign words_loaded = words_ff;

endmodule

[hdl/brtl_query.sv]
// ----------------------------------------------------------------------------
// brtl_query
// Query path: issue memory reads, select relative count, popcount the masked
// word, add, and hold the result in the output register.
// ----------------------------------------------------------------------------
module brtl_query #(
   parameter int MAX_WORDS = brtl_pkg::MAX_WORDS_DEF,
   parameter int AW        = $clog2(MAX_WORDS),
   parameter int BW        = (((MAX_WORDS + 7) / 8) > 1) ? $clog2((MAX_WORDS + 7) / 8) : 1,
   parameter int CW        = $clog2(MAX_WORDS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [brtl_pkg::POS_W-1:0]  position,
   input  logic [CW-1:0]               words_loaded,
   output logic                        idle,
   output logic                        rd_en,
   output logic [AW-1:0]               word_rd_addr,
   output logic [BW-1:0]               blk_rd_addr,
   input  logic [brtl_pkg::WORD_W-1:0] word_rd_data,
   input  logic [brtl_pkg::BLK_W-1:0]  blk_rd_data,
   brtl_rsp_if.source                  rsp_chan
);
   import brtl_pkg::*;

   localparam int WIDX_W = POS_W - BIT_W;
   localparam int XW     = (AW > WIDX_W) ? AW : WIDX_W;
   localparam int LW     = ((CW + BIT_W) > POS_W) ? (CW + BIT_W) : POS_W;

   q_state_type       state_ff, state_in;
   logic              oor_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [BIT_W-1:0]  bit_ff;
   logic [POP_W-1:0]  pop_ff;
   logic [REL_W-1:0]  rel_ff, rel_sel;
   logic [ONES_W-1:0] abs_ff;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              flag_ff, flag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]     widx;
   logic [XW-1:0]     bidx;
   logic [WORD_W-1:0] mask;
   logic [ONES_W-1:0] total;
   logic              slot_free;

   assign widx         = XW'(position[POS_W-1:BIT_W]);
   assign bidx         = widx >> SLOT_W;
   assign word_rd_addr = widx[AW-1:0];
   assign blk_rd_addr  = bidx[BW-1:0];
   assign rd_en        = start;
   assign idle         = (state_ff == Q_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      mask    = (WORD_W'(1) << bit_ff) - WORD_W'(1);
      rel_sel = '0;
      for (int f = 1; f < WORDS_PER_BLOCK; f++) begin
         if (slot_ff == SLOT_W'(f)) begin
            rel_sel = blk_rd_data[REL_W*(WORDS_PER_BLOCK-1-f) +: REL_W];
         end
      end
      total = abs_ff + ONES_W'(rel_ff) + ONES_W'(pop_ff);
   end

   always_comb begin
      state_in     = state_ff;
      rank_in      = rank_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         Q_IDLE: begin
            if (start) begin
               state_in = Q_LOOK;
            end
         end
         Q_LOOK: begin
            state_in = Q_SUM;
         end
         Q_SUM: begin
            if (slot_free) begin
               rank_in      = oor_ff ? '0 : total[RANK_W-1:0];
               flag_in      = oor_ff;
               rsp_valid_in = 1'b1;
               state_in     = Q_IDLE;
            end
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= Q_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rank_ff <= rank_in;
      flag_ff <= flag_in;
      if (start) begin
         oor_ff  <= (LW'(position) >= LW'({words_loaded, BIT_W'(0)}));
         slot_ff <= widx[SLOT_W-1:0];
         bit_ff  <= position[BIT_W-1:0];
      end
      if (state_ff == Q_LOOK) begin
         pop_ff <= ones64(word_rd_data & mask);
         rel_ff <= rel_sel;
         abs_ff <= blk_rd_data[BLK_W-1:REL_ALL_W];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.rank_count   = rank_ff;
   assign rsp_chan.out_of_range = flag_ff;

endmodule
